@@ rtl/tts_pkg.sv @@
// Package for the tick task scheduler: shared constants, codes and the
// command and status structs between controller and datapath.
// No dependencies.
`default_nettype none
package tts_pkg;
	localparam int MAX_TASK_SLOTS_DEF = 8;

	localparam logic [7:0] SLICE_ONE_RST   = 8'd15;
	localparam logic [7:0] SLICE_TWO_RST   = 8'd10;
	localparam logic [7:0] SLICE_THREE_RST = 8'd5;
	localparam logic [7:0] PRIO_ZERO_SLICE = 8'd255;

	localparam logic [2:0] KIND_TICK    = 3'd0;
	localparam logic [2:0] KIND_CREATE  = 3'd1;
	localparam logic [2:0] KIND_SLEEP   = 3'd2;
	localparam logic [2:0] KIND_SUSPEND = 3'd3;
	localparam logic [2:0] KIND_RESUME  = 3'd4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_DUP_ID    = 3'd2;
	localparam logic [2:0] ST_DUP_PRIO0 = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;

	localparam logic [1:0] REG_SLICE_ONE   = 2'd0;
	localparam logic [1:0] REG_SLICE_TWO   = 2'd1;
	localparam logic [1:0] REG_SLICE_THREE = 2'd2;

	typedef logic [4:0] op_t;
	localparam op_t OP_NONE    = 5'd0;
	localparam op_t OP_TICK    = 5'd1;
	localparam op_t OP_WAKE    = 5'd2;
	localparam op_t OP_CHARGE  = 5'd3;
	localparam op_t OP_P0      = 5'd4;
	localparam op_t OP_DECIDE  = 5'd5;
	localparam op_t OP_RR_STEP = 5'd6;
	localparam op_t OP_FINISH  = 5'd7;
	localparam op_t OP_CREATE  = 5'd8;
	localparam op_t OP_CSCAN   = 5'd9;
	localparam op_t OP_CWRITE  = 5'd10;
	localparam op_t OP_SLEEP   = 5'd11;
	localparam op_t OP_FIND    = 5'd12;
	localparam op_t OP_FSCAN   = 5'd13;
	localparam op_t OP_PTR_RUN = 5'd14;
	localparam op_t OP_RESULT  = 5'd15;

	typedef struct packed {
		logic load;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic no_run;
		logic last;
		logic p0_hit;
		logic need_rr;
		logic rr_done;
		logic elig;
		logic id_hit;
		logic clash;
	} sts_t;
endpackage
`default_nettype wire

@@ rtl/tick_task_scheduler.sv @@
// Top level of the tick task scheduler: slice registers on the APB port,
// controller and datapath. Depends on tts_pkg, tts_ctrl and tts_dp.
`default_nettype none
// A request is taken when start is high and busy is low; its result appears
// on the result ports for one cycle with done high, and the receiver cannot
// stall it. The next request may be taken in the cycle in which done is
// high. The controller walks the task table one entry per cycle through a
// single read pointer for the wake scan and the priority-0 scan, and passes
// through S_RR and S_RRCHK for each candidate in the round robin. Slice
// registers sit at byte addresses 0, 4 and 8 and affect tasks created later.
module tick_task_scheduler import tts_pkg::*; #(
	parameter int MAX_TASK_SLOTS = MAX_TASK_SLOTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  kind,
	input  wire logic [7:0]  task_id,
	input  wire logic [1:0]  priority_req,
	input  wire logic [31:0] delay_ms,
	output logic             done,
	output logic [2:0]       current_index,
	output logic [7:0]       current_id,
	output logic [1:0]       current_priority,
	output logic [3:0]       task_count,
	output logic [63:0]      now_ms,
	output logic [2:0]       status,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	logic [7:0] slice_one_q, slice_two_q, slice_three_q;
	cmd_t cmd;
	sts_t sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_one_q   <= SLICE_ONE_RST;
			slice_two_q   <= SLICE_TWO_RST;
			slice_three_q <= SLICE_THREE_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_SLICE_ONE:   slice_one_q   <= pwdata[7:0];
				REG_SLICE_TWO:   slice_two_q   <= pwdata[7:0];
				REG_SLICE_THREE: slice_three_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SLICE_ONE:   prdata = {24'd0, slice_one_q};
			REG_SLICE_TWO:   prdata = {24'd0, slice_two_q};
			REG_SLICE_THREE: prdata = {24'd0, slice_three_q};
			default:         prdata = 32'd0;
		endcase
	end

	tts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	tts_dp #(.MAX_TASK_SLOTS(MAX_TASK_SLOTS)) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.kind             (kind),
		.task_id          (task_id),
		.priority_req     (priority_req),
		.delay_ms         (delay_ms),
		.slice_one        (slice_one_q),
		.slice_two        (slice_two_q),
		.slice_three      (slice_three_q),
		.done             (done),
		.current_index    (current_index),
		.current_id       (current_id),
		.current_priority (current_priority),
		.task_count       (task_count),
		.now_ms           (now_ms),
		.status           (status)
	);
endmodule
`default_nettype wire

@@ rtl/tts_ctrl.sv @@
// Controller state machine of the tick task scheduler.
// Depends on tts_pkg; drives tts_dp through cmd_t, reads sts_t.
`default_nettype none
module tts_ctrl import tts_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [2:0] kind,
	input  wire sts_t       sts,
	output cmd_t            cmd,
	output logic            busy
);
	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_TICK   = 5'd1;
	localparam logic [4:0] S_WAKE   = 5'd2;
	localparam logic [4:0] S_CHARGE = 5'd3;
	localparam logic [4:0] S_P0     = 5'd4;
	localparam logic [4:0] S_DECIDE = 5'd5;
	localparam logic [4:0] S_RR     = 5'd6;
	localparam logic [4:0] S_RRCHK  = 5'd7;
	localparam logic [4:0] S_FINISH = 5'd8;
	localparam logic [4:0] S_CREATE = 5'd9;
	localparam logic [4:0] S_CSCAN  = 5'd10;
	localparam logic [4:0] S_CWRITE = 5'd11;
	localparam logic [4:0] S_SLEEP  = 5'd12;
	localparam logic [4:0] S_FIND   = 5'd13;
	localparam logic [4:0] S_FSCAN  = 5'd14;
	localparam logic [4:0] S_ORD    = 5'd15;
	localparam logic [4:0] S_OUT    = 5'd16;

	logic [4:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.op   = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					case (kind)
						KIND_TICK:    state_d = S_TICK;
						KIND_CREATE:  state_d = S_CREATE;
						KIND_SLEEP:   state_d = S_SLEEP;
						KIND_SUSPEND: state_d = S_FIND;
						KIND_RESUME:  state_d = S_FIND;
						default:      state_d = S_ORD;
					endcase
				end
			end
			S_TICK: begin
				cmd.op  = OP_TICK;
				state_d = sts.no_run ? S_ORD : S_WAKE;
			end
			S_WAKE: begin
				cmd.op = OP_WAKE;
				if (sts.last) state_d = S_CHARGE;
			end
			S_CHARGE: begin
				cmd.op  = OP_CHARGE;
				state_d = S_P0;
			end
			S_P0: begin
				cmd.op = OP_P0;
				if (sts.p0_hit) state_d = S_FINISH;
				else if (sts.last) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.op  = OP_DECIDE;
				state_d = sts.need_rr ? S_RR : S_FINISH;
			end
			S_RR: begin
				cmd.op  = OP_RR_STEP;
				state_d = sts.rr_done ? S_FINISH : S_RRCHK;
			end
			S_RRCHK: begin
				state_d = sts.elig ? S_FINISH : S_RR;
			end
			S_FINISH: begin
				cmd.op  = OP_FINISH;
				state_d = S_ORD;
			end
			S_CREATE: begin
				cmd.op = OP_CREATE;
				if (sts.full) state_d = S_ORD;
				else if (sts.empty) state_d = S_CWRITE;
				else state_d = S_CSCAN;
			end
			S_CSCAN: begin
				cmd.op = OP_CSCAN;
				if (sts.id_hit || sts.clash) state_d = S_ORD;
				else if (sts.last) state_d = S_CWRITE;
			end
			S_CWRITE: begin
				cmd.op  = OP_CWRITE;
				state_d = S_ORD;
			end
			S_SLEEP: begin
				cmd.op  = OP_SLEEP;
				state_d = S_ORD;
			end
			S_FIND: begin
				cmd.op  = OP_FIND;
				state_d = sts.empty ? S_ORD : S_FSCAN;
			end
			S_FSCAN: begin
				cmd.op = OP_FSCAN;
				if (sts.id_hit || sts.last) state_d = S_ORD;
			end
			S_ORD: begin
				cmd.op  = OP_PTR_RUN;
				state_d = S_OUT;
			end
			S_OUT: begin
				cmd.op  = OP_RESULT;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

@@ rtl/tts_dp.sv @@
// Datapath of the tick task scheduler: task table, counters, scan pointer
// and result registers. Depends on tts_pkg; commanded by tts_ctrl.
`default_nettype none
module tts_dp import tts_pkg::*; #(
	parameter int MAX_TASK_SLOTS = MAX_TASK_SLOTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	input  wire logic [2:0]  kind,
	input  wire logic [7:0]  task_id,
	input  wire logic [1:0]  priority_req,
	input  wire logic [31:0] delay_ms,
	input  wire logic [7:0]  slice_one,
	input  wire logic [7:0]  slice_two,
	input  wire logic [7:0]  slice_three,
	output logic             done,
	output logic [2:0]       current_index,
	output logic [7:0]       current_id,
	output logic [1:0]       current_priority,
	output logic [3:0]       task_count,
	output logic [63:0]      now_ms,
	output logic [2:0]       status
);
	localparam int IW = $clog2(MAX_TASK_SLOTS);
	localparam int CW = $clog2(MAX_TASK_SLOTS + 1);

	logic [7:0]  ident_q [MAX_TASK_SLOTS];
	logic [1:0]  prio_q  [MAX_TASK_SLOTS];
	logic [7:0]  slice_q [MAX_TASK_SLOTS];
	logic [7:0]  left_q  [MAX_TASK_SLOTS];
	logic [63:0] wake_q  [MAX_TASK_SLOTS];
	logic [MAX_TASK_SLOTS-1:0] rdy_q, susp_q;

	logic [CW-1:0] count_q, cnt_q;
	logic [IW-1:0] run_q, ptr_q, nxt_q, cand;
	logic [63:0]   tick_q;
	logic [2:0]    kind_q, status_q;
	logic [7:0]    id_q, new_slice;
	logic [1:0]    preq_q;
	logic [31:0]   ms_q;

	logic [7:0]  ident_r, left_r, slice_r;
	logic [1:0]  prio_r;
	logic [63:0] wake_r;
	logic        rdy_r, susp_r, due, have;

	assign ident_r = ident_q[ptr_q];
	assign prio_r  = prio_q[ptr_q];
	assign slice_r = slice_q[ptr_q];
	assign left_r  = left_q[ptr_q];
	assign wake_r  = wake_q[ptr_q];
	assign rdy_r   = rdy_q[ptr_q];
	assign susp_r  = susp_q[ptr_q];
	assign due     = (tick_q >= wake_r);
	assign have    = (count_q != '0) && (CW'(run_q) < count_q);
	assign cand    = (CW'(nxt_q) + CW'(1) == count_q) ? '0 : nxt_q + IW'(1);

	always_comb begin
		sts.empty   = (count_q == '0);
		sts.full    = (count_q == CW'(MAX_TASK_SLOTS));
		sts.no_run  = !have;
		sts.last    = (CW'(ptr_q) + CW'(1) == count_q);
		sts.p0_hit  = (prio_r == 2'd0) && rdy_r;
		sts.need_rr = (left_r == 8'd0) || !rdy_r;
		sts.rr_done = (cnt_q + CW'(1) >= count_q);
		sts.elig    = rdy_r && (prio_r != 2'd0) && !susp_r;
		sts.id_hit  = (ident_r == id_q);
		sts.clash   = (preq_q == 2'd0) && (prio_r == 2'd0);
	end

	always_comb begin
		case (preq_q)
			2'd1:    new_slice = slice_one;
			2'd2:    new_slice = slice_two;
			2'd3:    new_slice = slice_three;
			default: new_slice = PRIO_ZERO_SLICE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			run_q   <= '0;
			tick_q  <= '0;
			done    <= 1'b0;
		end else begin
			done <= (cmd.op == OP_RESULT);
			if (cmd.op == OP_TICK) tick_q <= tick_q + 64'd1;
			if (cmd.op == OP_CWRITE) count_q <= count_q + CW'(1);
			if (cmd.op == OP_FINISH) run_q <= nxt_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q   <= kind;
			id_q     <= task_id;
			preq_q   <= priority_req;
			ms_q     <= delay_ms;
			status_q <= ST_OK;
		end
		case (cmd.op)
			OP_TICK: ptr_q <= '0;
			OP_WAKE: begin
				if (!rdy_r && due && !susp_r) rdy_q[ptr_q] <= 1'b1;
				ptr_q <= sts.last ? run_q : ptr_q + IW'(1);
			end
			OP_CHARGE: begin
				if (prio_r != 2'd0 && left_r != 8'd0) left_q[ptr_q] <= left_r - 8'd1;
				ptr_q <= '0;
			end
			OP_P0: begin
				if (sts.p0_hit) nxt_q <= ptr_q;
				else ptr_q <= sts.last ? run_q : ptr_q + IW'(1);
			end
			OP_DECIDE: begin
				nxt_q <= ptr_q;
				cnt_q <= '0;
				if (sts.need_rr) left_q[ptr_q] <= slice_r;
			end
			OP_RR_STEP: begin
				nxt_q <= cand;
				ptr_q <= cand;
				cnt_q <= cnt_q + CW'(1);
			end
			OP_CREATE: begin
				ptr_q <= '0;
				if (sts.full) status_q <= ST_FULL;
			end
			OP_CSCAN: begin
				if (sts.id_hit) status_q <= ST_DUP_ID;
				else if (sts.clash) status_q <= ST_DUP_PRIO0;
				ptr_q <= ptr_q + IW'(1);
			end
			OP_CWRITE: begin
				ident_q[count_q[IW-1:0]] <= id_q;
				prio_q[count_q[IW-1:0]]  <= preq_q;
				slice_q[count_q[IW-1:0]] <= new_slice;
				left_q[count_q[IW-1:0]]  <= new_slice;
				rdy_q[count_q[IW-1:0]]   <= 1'b1;
				susp_q[count_q[IW-1:0]]  <= 1'b0;
				wake_q[count_q[IW-1:0]]  <= '0;
			end
			OP_SLEEP: begin
				if (have) begin
					rdy_q[run_q]  <= 1'b0;
					wake_q[run_q] <= tick_q + 64'(ms_q);
				end else begin
					status_q <= ST_NOT_FOUND;
				end
			end
			OP_FIND: begin
				ptr_q <= '0;
				if (sts.empty) status_q <= ST_NOT_FOUND;
			end
			OP_FSCAN: begin
				if (sts.id_hit) begin
					if (kind_q == KIND_SUSPEND) begin
						susp_q[ptr_q] <= 1'b1;
						rdy_q[ptr_q]  <= 1'b0;
						if (ptr_q == run_q) wake_q[ptr_q] <= tick_q + 64'd1;
					end else begin
						susp_q[ptr_q] <= 1'b0;
						if (due) rdy_q[ptr_q] <= 1'b1;
					end
				end else if (sts.last) begin
					status_q <= ST_NOT_FOUND;
				end
				ptr_q <= ptr_q + IW'(1);
			end
			OP_PTR_RUN: ptr_q <= run_q;
			OP_RESULT: begin
				current_index    <= 3'(run_q);
				current_id       <= have ? ident_r : 8'd0;
				current_priority <= have ? prio_r : 2'd0;
				task_count       <= 4'(count_q);
				now_ms           <= tick_q;
				status           <= status_q;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for tick_task_scheduler: drives tick, create, sleep,
// suspend and resume requests and slice writes, and checks every result
// against a behavioural predictor of the task table. Depends on tts_pkg.
`default_nettype none
import tts_pkg::*;

typedef struct {
	bit [2:0]  idx;
	bit [7:0]  id;
	bit [1:0]  prio;
	bit [3:0]  cnt;
	bit [63:0] now;
	bit [2:0]  st;
} sched_report_t;

class sched_scoreboard;
	bit [7:0]  slice_one, slice_two, slice_three;
	bit [7:0]  ident[8];
	bit [1:0]  prio[8];
	bit [7:0]  slice[8];
	bit [7:0]  left[8];
	bit        ready[8];
	bit        susp[8];
	bit [63:0] wake[8];
	int unsigned count, running;
	bit [63:0] ticks;
	sched_report_t pending[$];
	int errors;

	function new();
		slice_one = SLICE_ONE_RST;
		slice_two = SLICE_TWO_RST;
		slice_three = SLICE_THREE_RST;
		count = 0;
		running = 0;
		ticks = 0;
		errors = 0;
	endfunction

	function void set_slice(bit [1:0] idx, bit [7:0] v);
		if (idx == REG_SLICE_ONE) slice_one = v;
		else if (idx == REG_SLICE_TWO) slice_two = v;
		else if (idx == REG_SLICE_THREE) slice_three = v;
	endfunction

	function int lookup(bit [7:0] id);
		for (int i = 0; i < count; i++)
			if (ident[i] == id) return i;
		return -1;
	endfunction

	function void advance_tick();
		int unsigned cur, nxt, checked;
		bit hit;
		cur = running;
		hit = 0;
		ticks++;
		if (count == 0 || cur >= count) return;
		for (int i = 0; i < count; i++)
			if (!ready[i] && ticks >= wake[i] && !susp[i]) ready[i] = 1;
		if (prio[cur] > 0 && left[cur] > 0) left[cur]--;
		nxt = cur;
		for (int i = 0; i < count; i++)
			if (prio[i] == 0 && ready[i]) begin
				nxt = i;
				hit = 1;
				break;
			end
		if (!hit && (left[cur] == 0 || !ready[cur])) begin
			left[cur] = slice[cur];
			checked = 0;
			forever begin
				nxt = (nxt + 1) % count;
				checked++;
				if (checked >= count) break;
				if (ready[nxt] && prio[nxt] != 0 && !susp[nxt]) break;
			end
		end
		running = nxt;
	endfunction

	function bit [2:0] create_task(bit [7:0] id, bit [1:0] p);
		bit [7:0] s;
		if (count >= 8) return ST_FULL;
		for (int i = 0; i < count; i++) begin
			if (ident[i] == id) return ST_DUP_ID;
			if (p == 0 && prio[i] == 0) return ST_DUP_PRIO0;
		end
		case (p)
			2'd1: s = slice_one;
			2'd2: s = slice_two;
			2'd3: s = slice_three;
			default: s = PRIO_ZERO_SLICE;
		endcase
		ident[count] = id;
		prio[count] = p;
		slice[count] = s;
		left[count] = s;
		ready[count] = 1;
		susp[count] = 0;
		wake[count] = 0;
		count++;
		return ST_OK;
	endfunction

	function void note_request(bit [2:0] kind, bit [7:0] id, bit [1:0] p, bit [31:0] ms);
		sched_report_t r;
		bit [2:0] st;
		int idx;
		bit have;
		st = ST_OK;
		have = count > 0 && running < count;
		case (kind)
			KIND_TICK: advance_tick();
			KIND_CREATE: st = create_task(id, p);
			KIND_SLEEP: begin
				if (have) begin
					ready[running] = 0;
					wake[running] = ticks + ms;
				end else st = ST_NOT_FOUND;
			end
			KIND_SUSPEND: begin
				idx = lookup(id);
				if (idx < 0) st = ST_NOT_FOUND;
				else begin
					susp[idx] = 1;
					ready[idx] = 0;
					if (idx == running) wake[idx] = ticks + 1;
				end
			end
			KIND_RESUME: begin
				idx = lookup(id);
				if (idx < 0) st = ST_NOT_FOUND;
				else begin
					susp[idx] = 0;
					if (ticks >= wake[idx]) ready[idx] = 1;
				end
			end
			default: ;
		endcase
		have = count > 0 && running < count;
		r.idx = running[2:0];
		r.id = have ? ident[running] : 8'd0;
		r.prio = have ? prio[running] : 2'd0;
		r.cnt = count[3:0];
		r.now = ticks;
		r.st = st;
		pending.push_back(r);
	endfunction

	function void compare(string name, bit [63:0] e, bit [63:0] a);
		if (e !== a) begin
			$display("%0t mismatch %s: expected %0d actual %0d", $realtime, name, e, a);
			errors++;
		end
	endfunction

	function void check_result(sched_report_t a);
		sched_report_t e;
		if (pending.size() == 0) begin
			$display("%0t unexpected result: index %0d id %0d", $realtime, a.idx, a.id);
			errors++;
			return;
		end
		e = pending.pop_front();
		compare("current_index", e.idx, a.idx);
		compare("current_id", e.id, a.id);
		compare("current_priority", e.prio, a.prio);
		compare("task_count", e.cnt, a.cnt);
		compare("now_ms", e.now, a.now);
		compare("status", e.st, a.st);
	endfunction
endclass

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk, arst_n, start, busy, done;
	logic [2:0]  kind, current_index, status;
	logic [7:0]  task_id, current_id;
	logic [1:0]  priority_req, current_priority;
	logic [31:0] delay_ms, pwdata, prdata;
	logic [3:0]  task_count, paddr;
	logic [63:0] now_ms;
	logic        psel, penable, pwrite, pready;

	sched_scoreboard sb = new();
	int unsigned cycles = 0;

	tick_task_scheduler DUT (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 600000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (arst_n && done)
			sb.check_result('{current_index, current_id, current_priority, task_count,
				now_ms, status});
	end

	task automatic hold_gap();
		int r, g;
		r = $urandom_range(99);
		g = r < 55 ? 0 : r < 90 ? $urandom_range(3, 1) : $urandom_range(40, 10);
		if (g > 0) begin
			start <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic send_request(bit [2:0] k, bit [7:0] id, bit [1:0] p, bit [31:0] ms);
		hold_gap();
		kind <= k;
		task_id <= id;
		priority_req <= p;
		delay_ms <= ms;
		start <= 1;
		forever begin
			@(negedge clk);
			if (!busy) break;
		end
		@(posedge clk);
		sb.note_request(k, id, p, ms);
	endtask

	task automatic drain();
		start <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_slice(bit [1:0] idx, bit [7:0] v);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'd0, 8'($urandom_range(255)), v};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		sb.set_slice(idx, v);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	function automatic bit [7:0] pick_slice();
		int r;
		r = $urandom_range(9);
		return r == 0 ? 8'd1 : r == 1 ? 8'd255 : 8'($urandom_range(12, 1));
	endfunction

	task automatic random_request();
		int r, n;
		bit [7:0] id;
		r = $urandom_range(99);
		n = sb.count;
		id = (n > 0 && $urandom_range(9) != 0) ? sb.ident[$urandom_range(n - 1)] :
			8'($urandom_range(255));
		if (r < 50) send_request(KIND_TICK, 8'($urandom), 2'($urandom), $urandom);
		else if (r < 62) send_request(KIND_SLEEP, 8'($urandom), 2'($urandom),
			$urandom_range(9) == 0 ? $urandom_range(60) : $urandom_range(6));
		else if (r < 74) send_request(KIND_SUSPEND, id, 2'($urandom), $urandom);
		else if (r < 92) send_request(KIND_RESUME, id, 2'($urandom), $urandom);
		else if (r < 98) send_request(KIND_CREATE, 8'($urandom_range(255)),
			2'($urandom_range(3, n < 4 ? 1 : 0)), $urandom);
		else send_request(3'($urandom_range(7, 5)), 8'($urandom), 2'($urandom), $urandom);
	endtask

	initial begin
		arst_n = 0;
		start = 0;
		kind = 0;
		task_id = 0;
		priority_req = 0;
		delay_ms = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_request(KIND_TICK, 8'd0, 2'd0, 32'd0);
		send_request(KIND_SLEEP, 8'd0, 2'd0, 32'd3);
		send_request(KIND_SUSPEND, 8'd7, 2'd0, 32'd0);
		send_request(KIND_RESUME, 8'd7, 2'd0, 32'd0);
		send_request(3'd5, 8'd255, 2'd3, 32'hFFFF_FFFF);
		send_request(3'd7, 8'd0, 2'd0, 32'd0);
		drain();
		write_slice(REG_SLICE_ONE, 8'd1);
		write_slice(REG_SLICE_TWO, 8'd255);
		write_slice(REG_SLICE_THREE, 8'd2);
		send_request(KIND_CREATE, 8'd0, 2'd3, 32'd0);
		send_request(KIND_CREATE, 8'd0, 2'd1, 32'd0);
		send_request(KIND_CREATE, 8'd17, 2'd1, 32'd0);
		send_request(KIND_CREATE, 8'd34, 2'd2, 32'd0);
		repeat (4) send_request(KIND_TICK, 8'd0, 2'd0, 32'd0);
		send_request(KIND_SUSPEND, 8'd17, 2'd0, 32'd0);
		send_request(KIND_TICK, 8'd0, 2'd0, 32'd0);
		send_request(KIND_RESUME, 8'd17, 2'd0, 32'd0);
		send_request(KIND_CREATE, 8'd255, 2'd0, 32'd0);
		send_request(KIND_CREATE, 8'd9, 2'd0, 32'd0);
		send_request(KIND_TICK, 8'd0, 2'd0, 32'd0);
		send_request(KIND_SLEEP, 8'd0, 2'd0, 32'd2);
		repeat (3) send_request(KIND_TICK, 8'd0, 2'd0, 32'd0);
		send_request(KIND_SUSPEND, 8'd255, 2'd0, 32'd0);
		send_request(KIND_TICK, 8'd0, 2'd0, 32'd0);
		send_request(KIND_RESUME, 8'd255, 2'd0, 32'd0);
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			write_slice(REG_SLICE_ONE, pick_slice());
			write_slice(REG_SLICE_TWO, pick_slice());
			write_slice(REG_SLICE_THREE, pick_slice());
			repeat (100) random_request();
			drain();
		end
		write_slice(REG_SLICE_ONE, 8'd255);
		write_slice(REG_SLICE_TWO, 8'd1);
		write_slice(REG_SLICE_THREE, 8'd255);
		send_request(KIND_CREATE, 8'd100, 2'd2, 32'd0);
		send_request(KIND_SLEEP, 8'd0, 2'd0, 32'd0);
		send_request(KIND_TICK, 8'd0, 2'd0, 32'd0);
		send_request(KIND_SLEEP, 8'd0, 2'd0, 32'hFFFF_FFFF);
		repeat (5) send_request(KIND_TICK, 8'd0, 2'd0, 32'd0);
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire
